/* sv/htia_pkg.sv */
// Shared constants, codes and controller/datapath types for the handle table allocator.
package htia_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int TAG_BITS_DEFAULT = 32;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 8;
   localparam int CNT_W    = 9;
   localparam int STATUS_W = 2;

   // bitmap bits examined per scan cycle
   localparam int SCAN_GROUP = 16;

   localparam logic [CNT_W-1:0] FREE_KEPT_RESET = 9'd100;

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_ADD    = 2'd0;
   localparam kind_type KIND_REMOVE = 2'd1;
   localparam kind_type KIND_FIND   = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_RANGE    = 2'd1;
   localparam status_type STATUS_FULL     = 2'd2;
   localparam status_type STATUS_ZERO_TAG = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FREE_SCAN,
      ST_EMPTY_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start_free;
      logic start_empty;
      logic scan_free;
      logic scan_empty;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic add_go;
      logic free_nonempty;
      logic len_zero;
      logic free_hit;
      logic empty_hit;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

/* sv/htia_if.sv */
// Request and response channel interfaces for the handle table allocator.
interface htia_req_if #(
   parameter int TAG_W = htia_pkg::TAG_BITS_DEFAULT
);
   import htia_pkg::*;

   logic             valid;
   logic             ready;
   kind_type         kind;
   logic [ID_W-1:0]  slot_id;
   logic [TAG_W-1:0] object_tag;

   modport source (output valid, kind, slot_id, object_tag, input ready);
   modport sink   (input valid, kind, slot_id, object_tag, output ready);
endinterface

interface htia_rsp_if #(
   parameter int TAG_W = htia_pkg::TAG_BITS_DEFAULT
);
   import htia_pkg::*;

   logic             valid;
   logic             ready;
   status_type       status;
   logic [ID_W-1:0]  assigned_id;
   logic [TAG_W-1:0] found_tag;
   logic [CNT_W-1:0] live_count;

   modport source (output valid, status, assigned_id, found_tag, live_count, input ready);
   modport sink   (input valid, status, assigned_id, found_tag, live_count, output ready);
endinterface

/* sv/htia_ctrl.sv */
// Sequencing state machine for the handle table allocator.
module htia_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output htia_pkg::cmd_type cmd,
   input  htia_pkg::sts_type sts
);
   import htia_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.add_go && sts.free_nonempty) begin
               state_in = ST_FREE_SCAN;
            end else if (sts.add_go && !sts.len_zero) begin
               state_in = ST_EMPTY_SCAN;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_FREE_SCAN: begin
            if (sts.free_hit) state_in = ST_COMMIT;
         end
         ST_EMPTY_SCAN: begin
            if (sts.empty_hit || sts.scan_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.out_free) state_in = req_valid ? ST_DECODE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE) || (state_ff == ST_COMMIT && sts.out_free);
      cmd             = '0;
      cmd.load        = req_valid && req_ready;
      cmd.start_free  = (state_ff == ST_DECODE) && sts.add_go && sts.free_nonempty;
      cmd.start_empty = (state_ff == ST_DECODE) && sts.add_go && !sts.free_nonempty
                        && !sts.len_zero;
      cmd.scan_free   = (state_ff == ST_FREE_SCAN);
      cmd.scan_empty  = (state_ff == ST_EMPTY_SCAN);
      cmd.commit      = (state_ff == ST_COMMIT) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/htia_dp.sv */
// Datapath: slot memory, occupancy and free bitmaps, group scanner and response register.
module htia_dp #(
   parameter int CAPACITY = htia_pkg::CAPACITY_DEFAULT,
   parameter int TAG_BITS = htia_pkg::TAG_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  htia_pkg::cmd_type           cmd,
   output htia_pkg::sts_type           sts,
   input  logic                        csr_wr_en,
   input  logic [htia_pkg::CNT_W-1:0]  csr_wr_data,
   input  htia_pkg::kind_type          req_kind,
   input  logic [htia_pkg::ID_W-1:0]   req_slot_id,
   input  logic [TAG_BITS-1:0]         req_object_tag,
   htia_rsp_if.source                  rsp_if
);
   import htia_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int GRP_W  = (CAPACITY < SCAN_GROUP) ? CAPACITY : SCAN_GROUP;
   localparam int NGRP   = (CAPACITY + GRP_W - 1) / GRP_W;
   localparam int GI_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int GB_W   = $clog2(GRP_W);
   localparam int PAD_W  = NGRP * GRP_W;
   localparam int POS_W  = $clog2(PAD_W + 1);
   localparam int CMP_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;

   // current transaction
   kind_type            kind_ff;
   logic [ID_W-1:0]     id_ff;
   logic [TAG_BITS-1:0] tag_ff;

   logic [CAPACITY-1:0] occ_ff, occ_in;
   logic [CAPACITY-1:0] free_ff, free_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    free_cnt_ff, free_cnt_in;
   logic [LEN_W-1:0]    live_ff, live_in;
   logic [CNT_W-1:0]    max_free_ff;

   logic [GI_W-1:0]     grp_ff, grp_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic                hit_ff, hit_in;
   logic                from_free_ff, from_free_in;

   logic [TAG_BITS-1:0] slot_mem [CAPACITY];
   logic [TAG_BITS-1:0] rd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff;
   logic [ID_W-1:0]     given_ff;
   logic [TAG_BITS-1:0] found_ff;
   logic [CNT_W-1:0]    count_ff;

   logic [IDX_W-1:0]    id_idx;
   logic                in_range;
   logic                tag_zero;
   logic                add_go;
   logic                out_free;

   logic [PAD_W-1:0]    free_pad, occ_pad;
   logic [GRP_W-1:0]    free_grp, occ_grp, empty_grp;
   logic [POS_W-1:0]    base;
   logic [GB_W-1:0]     free_lo, empty_hi;
   logic [GI_W-1:0]     start_grp;

   logic                take;
   logic                append;
   logic [IDX_W-1:0]    tgt;
   status_type          status_c;
   logic [ID_W-1:0]     given_c;
   logic [TAG_BITS-1:0] found_c;

   assign id_idx   = IDX_W'(id_ff);
   assign in_range = CMP_W'(id_ff) < CMP_W'(len_ff);
   assign tag_zero = (tag_ff == '0);
   assign add_go   = (kind_ff == KIND_ADD) && !tag_zero;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // pad groups so the last one is full width; padded slots look occupied
   assign free_pad  = PAD_W'(free_ff);
   assign occ_pad   = ~PAD_W'(~occ_ff);
   assign free_grp  = free_pad[grp_ff * GRP_W +: GRP_W];
   assign occ_grp   = occ_pad[grp_ff * GRP_W +: GRP_W];
   assign base      = POS_W'(grp_ff) << GB_W;
   assign start_grp = GI_W'((POS_W'(len_ff) - POS_W'(1)) >> GB_W);

   always_comb begin
      empty_grp = '0;
      free_lo   = '0;
      empty_hi  = '0;
      for (int b = 0; b < GRP_W; b++) begin
         empty_grp[b] = !occ_grp[b] && ((base + POS_W'(b)) < POS_W'(len_ff));
      end
      for (int b = GRP_W - 1; b >= 0; b--) begin
         if (free_grp[b]) free_lo = GB_W'(b);
      end
      for (int b = 0; b < GRP_W; b++) begin
         if (empty_grp[b]) empty_hi = GB_W'(b);
      end
   end

   always_comb begin
      sts               = '0;
      sts.add_go        = add_go;
      sts.free_nonempty = (free_cnt_ff != '0);
      sts.len_zero      = (len_ff == '0);
      sts.free_hit      = |free_grp;
      sts.empty_hit     = |empty_grp;
      sts.scan_last     = (grp_ff == '0);
      sts.out_free      = out_free;
   end

   // outcome of the current transaction
   always_comb begin
      take     = 1'b0;
      append   = 1'b0;
      tgt      = pick_ff;
      status_c = STATUS_OK;
      given_c  = id_ff;
      found_c  = '0;
      case (kind_ff)
         KIND_ADD: begin
            given_c = '0;
            if (tag_zero) begin
               status_c = STATUS_ZERO_TAG;
            end else if (hit_ff) begin
               take = 1'b1;
            end else if (len_ff < LEN_W'(CAPACITY)) begin
               take   = 1'b1;
               append = 1'b1;
               tgt    = IDX_W'(len_ff);
            end else begin
               status_c = STATUS_FULL;
            end
            if (take) given_c = ID_W'(tgt);
         end
         KIND_REMOVE: begin
            if (!in_range) status_c = STATUS_RANGE;
         end
         KIND_FIND: begin
            if (!in_range) begin
               status_c = STATUS_RANGE;
            end else if (occ_ff[id_idx]) begin
               found_c = rd_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      occ_in       = occ_ff;
      free_in      = free_ff;
      len_in       = len_ff;
      free_cnt_in  = free_cnt_ff;
      live_in      = live_ff;
      grp_in       = grp_ff;
      pick_in      = pick_ff;
      hit_in       = hit_ff;
      from_free_in = from_free_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_if.ready) rsp_valid_in = 1'b0;

      if (cmd.start_free) begin
         grp_in       = '0;
         from_free_in = 1'b1;
      end
      if (cmd.start_empty) grp_in = start_grp;

      if (cmd.scan_free) begin
         if (|free_grp) begin
            pick_in = IDX_W'(base) + IDX_W'(free_lo);
            hit_in  = 1'b1;
         end else begin
            grp_in = grp_ff + GI_W'(1);
         end
      end
      if (cmd.scan_empty) begin
         if (|empty_grp) begin
            pick_in = IDX_W'(base) + IDX_W'(empty_hi);
            hit_in  = 1'b1;
         end else if (grp_ff != '0) begin
            grp_in = grp_ff - GI_W'(1);
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (take) begin
            occ_in[tgt] = 1'b1;
            if (!occ_ff[tgt]) live_in = live_ff + LEN_W'(1);
            if (from_free_ff) begin
               free_in[tgt] = 1'b0;
               free_cnt_in  = free_cnt_ff - LEN_W'(1);
            end
            if (append) len_in = len_ff + LEN_W'(1);
         end
         if (kind_ff == KIND_REMOVE && in_range) begin
            if (occ_ff[id_idx]) begin
               occ_in[id_idx] = 1'b0;
               live_in        = live_ff - LEN_W'(1);
            end
            if (!free_ff[id_idx] && (CMP_W'(free_cnt_ff) < CMP_W'(max_free_ff))) begin
               free_in[id_idx] = 1'b1;
               free_cnt_in     = free_cnt_ff + LEN_W'(1);
            end
         end
      end

      // a new transaction starts with no pick
      if (cmd.load) begin
         hit_in       = 1'b0;
         from_free_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         free_ff      <= '0;
         len_ff       <= '0;
         free_cnt_ff  <= '0;
         live_ff      <= '0;
         max_free_ff  <= FREE_KEPT_RESET;
         grp_ff       <= '0;
         hit_ff       <= 1'b0;
         from_free_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         free_ff      <= free_in;
         len_ff       <= len_in;
         free_cnt_ff  <= free_cnt_in;
         live_ff      <= live_in;
         grp_ff       <= grp_in;
         hit_ff       <= hit_in;
         from_free_ff <= from_free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) max_free_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         id_ff   <= req_slot_id;
         tag_ff  <= req_object_tag;
      end
      pick_ff <= pick_in;
      if (cmd.commit) begin
         status_ff <= status_c;
         given_ff  <= given_c;
         found_ff  <= found_c;
         count_ff  <= CNT_W'(live_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && take) slot_mem[tgt] <= tag_ff;
      rd_ff <= slot_mem[id_idx];
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.assigned_id = given_ff;
   assign rsp_if.found_tag   = found_ff;
   assign rsp_if.live_count  = count_ff;

   a_free_count: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff == LEN_W'($countones(free_ff)))
      else $error("free count out of step with free bitmap");

   a_live_count: assert property (@(posedge clock) disable iff (reset)
      live_ff == LEN_W'($countones(occ_ff)))
      else $error("live count out of step with occupancy bitmap");

   a_disjoint: assert property (@(posedge clock) disable iff (reset)
      (free_ff & occ_ff) == '0)
      else $error("slot both free-listed and occupied");

   a_free_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_free |-> free_cnt_ff != '0)
      else $error("free scan running on an empty free set");

endmodule

/* sv/handle_table_id_allocator_unit.sv */
// Handle table id allocator: add / remove / find on a bounded table of object tags.
//
// req_if carries one transaction (kind, slot_id, object_tag); rsp_if returns exactly one
// result per transaction (status, assigned_id, found_tag, live_count), in order.
// csr_wr_en / csr_wr_data write max_free_kept; write it only while no transaction is open.
// Remove, find, unused kinds and zero-tag adds pass from decode directly to commit,
// as does an add into an empty table with an empty free set. Any other add scans first:
// the free bitmap is scanned upward, or the occupancy bitmap
// downward from the table end, 16 slots per cycle; the scan sets the cost, and an add
// into a full table always walks the whole occupancy bitmap.
// A result sits in an output register; the next transaction is accepted in the cycle
// the result is written, so a stalled receiver holds at most one result and the block
// waits in its commit step until that register drains.
// Reset (synchronous, active high) clears the table length, counters and both bitmaps
// and loads max_free_kept with 100; no clearing pass is needed, slot memory
// contents are only read behind a set occupancy bit.
module handle_table_id_allocator_unit #(
   parameter int CAPACITY = htia_pkg::CAPACITY_DEFAULT,
   parameter int TAG_BITS = htia_pkg::TAG_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   htia_req_if.sink                   req_if,
   htia_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [htia_pkg::CNT_W-1:0] csr_wr_data
);
   import htia_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_if.ready = req_ready;

   htia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   htia_dp #(
      .CAPACITY (CAPACITY),
      .TAG_BITS (TAG_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_kind       (req_if.kind),
      .req_slot_id    (req_if.slot_id),
      .req_object_tag (req_if.object_tag),
      .rsp_if         (rsp_if)
   );

endmodule

/* tb/sv/handle_table_id_allocator_unit_test.sv */
// Self-checking testbench for the handle table id allocator: directed table, then random phases.
`timescale 1ns / 100ps

module handle_table_id_allocator_unit_test;
   import htia_pkg::*;

   localparam int SLOTS = CAPACITY_DEFAULT;
   localparam int TAG_W = TAG_BITS_DEFAULT;
   localparam kind_type KIND_UNUSED = 2'd3;

   typedef struct packed {
      status_type       status;
      logic [ID_W-1:0]  assigned_id;
      logic [TAG_W-1:0] found_tag;
      logic [CNT_W-1:0] live_count;
   } alloc_result_type;

   typedef struct {
      kind_type         kind;
      logic [ID_W-1:0]  id;
      logic [TAG_W-1:0] tag;
      bit               typed;
      alloc_result_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   htia_req_if req_ch ();
   htia_rsp_if rsp_ch ();

   handle_table_id_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // shadow copy of the table state
   logic [TAG_W-1:0] tag_store [SLOTS];
   bit               in_use    [SLOTS];
   bit               freed     [SLOTS];
   int unsigned      table_len;
   int unsigned      free_cnt;
   int unsigned      live_cnt;
   int unsigned      free_limit;

   alloc_result_type pending_results [$];
   int               mismatch_count = 0;
   bit               burst_mode = 1'b0;

   stim_row_type directed_rows [24] = '{
      '{KIND_FIND,    8'h00, 32'h0000_0000, 1'b1, '{STATUS_RANGE,    8'h00, 32'h0, 9'd0}},
      '{KIND_REMOVE,  8'hFF, 32'h0000_0000, 1'b1, '{STATUS_RANGE,    8'hFF, 32'h0, 9'd0}},
      '{KIND_ADD,     8'h00, 32'h0000_0000, 1'b1, '{STATUS_ZERO_TAG, 8'h00, 32'h0, 9'd0}},
      '{KIND_UNUSED,  8'hA5, 32'h5A5A_5A5A, 1'b1, '{STATUS_OK,       8'hA5, 32'h0, 9'd0}},
      '{KIND_ADD,     8'hFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,       8'h00, 32'h0, 9'd1}},
      '{KIND_ADD,     8'h00, 32'h0000_0001, 1'b1, '{STATUS_OK,       8'h01, 32'h0, 9'd2}},
      '{KIND_ADD,     8'h00, 32'h8000_0000, 1'b1, '{STATUS_OK,       8'h02, 32'h0, 9'd3}},
      '{KIND_FIND,    8'h00, 32'h0000_0000, 1'b1,
        '{STATUS_OK, 8'h00, 32'hFFFF_FFFF, 9'd3}},
      '{KIND_FIND,    8'h03, 32'h0000_0000, 1'b1, '{STATUS_RANGE,    8'h03, 32'h0, 9'd3}},
      '{KIND_REMOVE,  8'h01, 32'h0000_0000, 1'b1, '{STATUS_OK,       8'h01, 32'h0, 9'd2}},
      // removing an empty slot again: still ok, no double entry in the free set
      '{KIND_REMOVE,  8'h01, 32'h0000_0000, 1'b1, '{STATUS_OK,       8'h01, 32'h0, 9'd2}},
      '{KIND_ADD,     8'h00, 32'h1234_5678, 1'b1, '{STATUS_OK,       8'h01, 32'h0, 9'd3}},
      '{KIND_FIND,    8'h01, 32'h0000_0000, 1'b1,
        '{STATUS_OK, 8'h01, 32'h1234_5678, 9'd3}},
      '{KIND_UNUSED,  8'hFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,       8'hFF, 32'h0, 9'd3}},
      '{KIND_REMOVE,  8'h00, 32'h0000_0000, 1'b0, '0},
      '{KIND_REMOVE,  8'h02, 32'h0000_0000, 1'b0, '0},
      '{KIND_ADD,     8'h00, 32'hDEAD_BEEF, 1'b0, '0},
      '{KIND_ADD,     8'h00, 32'h0000_FFFF, 1'b0, '0},
      '{KIND_FIND,    8'h02, 32'h0000_0000, 1'b0, '0},
      '{KIND_ADD,     8'h00, 32'h7F00_0001, 1'b0, '0},
      '{KIND_FIND,    8'h00, 32'h0000_0000, 1'b0, '0},
      '{KIND_REMOVE,  8'h03, 32'h0000_0000, 1'b0, '0},
      '{KIND_FIND,    8'h03, 32'h0000_0000, 1'b0, '0},
      '{KIND_ADD,     8'h00, 32'hAAAA_5555, 1'b0, '0}
   };

   function automatic alloc_result_type predict_alloc(input kind_type k,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [TAG_W-1:0] tag);
      alloc_result_type r;
      int               pick;
      r.status      = STATUS_OK;
      r.assigned_id = id;
      r.found_tag   = '0;
      pick          = -1;
      case (k)
         KIND_ADD: begin
            r.assigned_id = '0;
            if (tag == '0) begin
               r.status = STATUS_ZERO_TAG;
            end else begin
               if (free_cnt != 0) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (freed[i]) begin
                        pick = i;
                        break;
                     end
                  end
               end
               if (pick >= 0) begin
                  freed[pick] = 1'b0;
                  free_cnt--;
               end else begin
                  // highest empty slot below the table end
                  for (int i = 0; i < table_len; i++) begin
                     if (!in_use[i]) pick = i;
                  end
                  if (pick < 0 && table_len < SLOTS) begin
                     pick = table_len;
                     table_len++;
                  end
               end
               if (pick < 0) begin
                  r.status = STATUS_FULL;
               end else begin
                  tag_store[pick] = tag;
                  if (!in_use[pick]) begin
                     in_use[pick] = 1'b1;
                     live_cnt++;
                  end
                  r.assigned_id = pick[ID_W-1:0];
               end
            end
         end
         KIND_REMOVE: begin
            if (id < table_len) begin
               if (in_use[id]) begin
                  in_use[id] = 1'b0;
                  live_cnt--;
               end
               tag_store[id] = '0;
               if (!freed[id] && free_cnt < free_limit) begin
                  freed[id] = 1'b1;
                  free_cnt++;
               end
            end else begin
               r.status = STATUS_RANGE;
            end
         end
         KIND_FIND: begin
            if (id < table_len) begin
               if (in_use[id]) r.found_tag = tag_store[id];
            end else begin
               r.status = STATUS_RANGE;
            end
         end
         default: ;
      endcase
      r.live_count = live_cnt[CNT_W-1:0];
      return r;
   endfunction

   function automatic logic [TAG_W-1:0] rand_tag();
      logic [TAG_W-1:0] t;
      case ($urandom_range(0, 15))
         0:       t = '0;
         1:       t = '1;
         2:       t = 32'h1 << $urandom_range(0, TAG_W - 1);
         default: t = $urandom;
      endcase
      return t;
   endfunction

   task automatic send_item(input kind_type k, input logic [ID_W-1:0] id,
                            input logic [TAG_W-1:0] tag, input bit typed,
                            input alloc_result_type want);
      int               gap;
      alloc_result_type predicted;
      gap = burst_mode ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= k;
      req_ch.slot_id    <= id;
      req_ch.object_tag <= tag;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_alloc(k, id, tag);
      pending_results.insert(pending_results.size(), typed ? want : predicted);
   endtask

   task automatic write_free_limit(input logic [CNT_W-1:0] value);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      free_limit = value;
   endtask

   task automatic run_random(input int count, input int add_pct, input int rm_pct);
      int               pct;
      kind_type         k;
      logic [ID_W-1:0]  id;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         pct = $urandom_range(0, 99);
         if (pct < add_pct)               k = KIND_ADD;
         else if (pct < add_pct + rm_pct) k = KIND_REMOVE;
         else if (pct < 95)               k = KIND_FIND;
         else                             k = KIND_UNUSED;
         // mostly ids inside the table, now and then anywhere
         if (table_len == 0 || $urandom_range(0, 9) == 0) id = ID_W'($urandom_range(0, 255));
         else id = ID_W'($urandom_range(0, table_len - 1));
         send_item(k, id, rand_tag(), 1'b0, '0);
      end
   endtask

   // add until every slot is live, then push a few adds into the full table
   task automatic fill_table();
      while (live_cnt < SLOTS)
         send_item(KIND_ADD, ID_W'($urandom), rand_tag() | 32'h1, 1'b0, '0);
      repeat (3) send_item(KIND_ADD, ID_W'($urandom), $urandom | 32'h100, 1'b0, '0);
   endtask

   task automatic compare_field(input string name, input logic [TAG_W-1:0] want,
                                input logic [TAG_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      alloc_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction, expected none, actual %h %h %h %h",
                     $time, rsp_ch.status, rsp_ch.assigned_id, rsp_ch.found_tag,
                     rsp_ch.live_count);
         end else begin
            want = pending_results.pop_front();
            compare_field("status", TAG_W'(want.status), TAG_W'(rsp_ch.status));
            compare_field("assigned_id", TAG_W'(want.assigned_id),
                          TAG_W'(rsp_ch.assigned_id));
            compare_field("found_tag", want.found_tag, rsp_ch.found_tag);
            compare_field("live_count", TAG_W'(want.live_count),
                          TAG_W'(rsp_ch.live_count));
         end
      end
   end

   initial begin : rsp_sink
      int stall;
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 9);
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && !reset));
      end
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_ADD;
      req_ch.slot_id    = '0;
      req_ch.object_tag = '0;
      rsp_ch.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      for (int i = 0; i < SLOTS; i++) begin
         tag_store[i] = '0;
         in_use[i]    = 1'b0;
         freed[i]     = 1'b0;
      end
      table_len  = 0;
      free_cnt   = 0;
      live_cnt   = 0;
      free_limit = FREE_KEPT_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_item(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].tag,
                   directed_rows[r].typed, directed_rows[r].want);

      run_random(200, 50, 30);
      write_free_limit(9'd1);
      run_random(200, 60, 30);
      write_free_limit(9'd0);
      run_random(250, 90, 5);
      fill_table();
      write_free_limit(9'd256);
      run_random(250, 30, 55);
      write_free_limit(CNT_W'($urandom_range(2, 255)));
      run_random(250, 55, 35);
      write_free_limit(9'd0);
      run_random(150, 95, 3);
      fill_table();
      write_free_limit(FREE_KEPT_RESET);
      run_random(400, 45, 35);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
